[rtl/core/mgss_pkg.sv]
// shared types for the modular geometric series sum unit
package mgss_pkg;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_RED_B   = 10'b00_0000_0010,
      ST_RED_D   = 10'b00_0000_0100,
      ST_LOOP    = 10'b00_0000_1000,
      ST_MUL_AP  = 10'b00_0001_0000,
      ST_MUL_AQ  = 10'b00_0010_0000,
      ST_MUL_PP  = 10'b00_0100_0000,
      ST_MUL_PQ  = 10'b00_1000_0000,
      ST_MUL_FIN = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } state_type;

endpackage

[rtl/core/modular_geometric_series_sum_unit.sv]
// top level: multiplier * (1 + base + ... + base^(count-1)) mod modulus
//
//  channel  dir  ports                                          handshake
//  req      in   req_count, req_base, req_multiplier, req_modulus req_valid / req_stall
//  rsp      out  rsp_sum_mod                                     rsp_valid / rsp_stall
//
// one transaction at a time; base and multiplier are first reduced in turn by the serial reducer
// each count bit up to the highest set one costs one loop step plus two (bit clear) or
// four (bit set) serial multiplies, then one final multiply
// the worst-case run time is set by the shared serial multiplier
// reset is synchronous and clears control state only
// a finished result waits in the output register; a new transaction is taken meanwhile
module modular_geometric_series_sum_unit
   import mgss_pkg::*;
#(
   parameter int MOD_WIDTH   = 32,
   parameter int COUNT_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COUNT_WIDTH-1:0] req_count,
   input  logic [MOD_WIDTH-1:0]   req_base,
   input  logic [MOD_WIDTH-1:0]   req_multiplier,
   input  logic [MOD_WIDTH-1:0]   req_modulus,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [MOD_WIDTH-1:0]   rsp_sum_mod
);

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [MOD_WIDTH-1:0]   mod_ff, mod_in;
   logic [MOD_WIDTH-1:0]   mult_ff, mult_in;
   logic [MOD_WIDTH-1:0]   a_ff, a_in;
   logic [MOD_WIDTH-1:0]   s_ff, s_in;
   logic [MOD_WIDTH-1:0]   p_ff, p_in;
   logic [MOD_WIDTH-1:0]   q_ff, q_in;
   logic [MOD_WIDTH-1:0]   tmp_ff, tmp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0]   rsp_sum_ff, rsp_sum_in;

   logic                   red_start;
   logic [MOD_WIDTH-1:0]   red_value;
   logic                   red_done;
   logic [MOD_WIDTH-1:0]   red_rem;
   logic                   mul_start;
   logic [MOD_WIDTH-1:0]   mul_x;
   logic [MOD_WIDTH-1:0]   mul_y;
   logic                   mul_done;
   logic [MOD_WIDTH-1:0]   mul_prod;
   logic [MOD_WIDTH-1:0]   one_mod;

   function automatic logic [MOD_WIDTH-1:0] mod_add(
      input logic [MOD_WIDTH-1:0] u,
      input logic [MOD_WIDTH-1:0] v,
      input logic [MOD_WIDTH-1:0] m
   );
      logic [MOD_WIDTH:0] t;
      t = {1'b0, u} + {1'b0, v};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[MOD_WIDTH-1:0];
   endfunction

   assign one_mod = {{(MOD_WIDTH-1){1'b0}}, (mod_ff != MOD_WIDTH'(1))};

   mgss_mod_reduce #(
      .WIDTH(MOD_WIDTH)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (red_value),
      .modulus   ((state_ff == ST_IDLE) ? req_modulus : mod_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   mgss_mod_mul #(
      .WIDTH(MOD_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .modulus (mod_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mod_in       = mod_ff;
      mult_in      = mult_ff;
      a_in         = a_ff;
      s_in         = s_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      red_start    = 1'b0;
      red_value    = mult_ff;
      mul_start    = 1'b0;
      mul_x        = p_ff;
      mul_y        = p_ff;
      case (state_ff)
         ST_IDLE: begin
            red_value = req_base;
            if (req_valid) begin
               count_in = req_count;
               mod_in   = req_modulus;
               mult_in  = req_multiplier;
               if (req_modulus == '0) begin
                  tmp_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  red_start = 1'b1;
                  state_in  = ST_RED_B;
               end
            end
         end
         ST_RED_B: begin
            if (red_done) begin
               p_in      = red_rem;
               red_start = 1'b1;
               state_in  = ST_RED_D;
            end
         end
         ST_RED_D: begin
            if (red_done) begin
               mult_in  = red_rem;
               a_in     = one_mod;
               s_in     = '0;
               q_in     = one_mod;
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            mul_start = 1'b1;
            if (count_ff == '0) begin
               mul_x    = mult_ff;
               mul_y    = s_ff;
               state_in = ST_MUL_FIN;
            end else if (count_ff[0]) begin
               mul_x    = a_ff;
               mul_y    = p_ff;
               state_in = ST_MUL_AP;
            end else begin
               state_in = ST_MUL_PP;
            end
         end
         ST_MUL_AP: begin
            mul_x = a_ff;
            mul_y = q_ff;
            if (mul_done) begin
               tmp_in    = mul_prod;
               mul_start = 1'b1;
               state_in  = ST_MUL_AQ;
            end
         end
         ST_MUL_AQ: begin
            if (mul_done) begin
               s_in      = mod_add(mul_prod, s_ff, mod_ff);
               a_in      = tmp_ff;
               mul_start = 1'b1;
               state_in  = ST_MUL_PP;
            end
         end
         ST_MUL_PP: begin
            mul_y = q_ff;
            if (mul_done) begin
               tmp_in    = mul_prod;
               mul_start = 1'b1;
               state_in  = ST_MUL_PQ;
            end
         end
         ST_MUL_PQ: begin
            if (mul_done) begin
               q_in     = mod_add(mul_prod, q_ff, mod_ff);
               p_in     = tmp_ff;
               count_in = count_ff >> 1;
               state_in = ST_LOOP;
            end
         end
         ST_MUL_FIN: begin
            if (mul_done) begin
               tmp_in   = mul_prod;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = tmp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff   <= count_in;
      mod_ff     <= mod_in;
      mult_ff    <= mult_in;
      a_ff       <= a_in;
      s_ff       <= s_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      tmp_ff     <= tmp_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sum_mod = rsp_sum_ff;

`ifndef SYNTHESIS
   a_mul_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_AP || state_ff == ST_MUL_AQ ||
                    state_ff == ST_MUL_PP || state_ff == ST_MUL_PQ ||
                    state_ff == ST_MUL_FIN))
      else $error("multiplier finished outside a multiply step");

   a_mul_result_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (mul_prod < mod_ff))
      else $error("multiplier result not below modulus");

   a_red_result_reduced: assert property (@(posedge clock) disable iff (reset)
      red_done |-> ((red_rem < mod_ff) && (state_ff == ST_RED_B || state_ff == ST_RED_D)))
      else $error("reduction result out of range or unexpected");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");
`endif

endmodule

[rtl/core/mgss_mod_reduce.sv]
// bit-serial remainder of a value by the modulus, msb first
module mgss_mod_reduce #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] value,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] val_ff, val_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] mod_ff, mod_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, val_ff[WIDTH-1]};
      if (trial >= {1'b0, mod_ff}) begin
         trial = trial - {1'b0, mod_ff};
      end
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         mod_in  = modulus;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial[WIDTH-1:0];
         val_in = val_ff << 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[rtl/core/mgss_mod_mul.sv]
// bit-serial shift-and-add modular multiplier, one multiplier bit per cycle
module mgss_mod_mul #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] mod_ff, mod_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   acc_sum;
   logic [WIDTH:0]   x_dbl;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_sum = {1'b0, acc_ff} + {1'b0, x_ff};
      if (acc_sum >= {1'b0, mod_ff}) begin
         acc_sum = acc_sum - {1'b0, mod_ff};
      end
      x_dbl = {x_ff, 1'b0};
      if (x_dbl >= {1'b0, mod_ff}) begin
         x_dbl = x_dbl - {1'b0, mod_ff};
      end
      if (start) begin
         x_in    = x;
         y_in    = y;
         acc_in  = '0;
         mod_in  = modulus;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff[0]) begin
            acc_in = acc_sum[WIDTH-1:0];
         end
         x_in   = x_dbl[WIDTH-1:0];
         y_in   = y_ff >> 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      mod_ff <= mod_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[sim/modular_geometric_series_sum_unit_tb.sv]
// self-checking testbench for the modular geometric series sum unit
module modular_geometric_series_sum_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MW = 32;
   localparam int CW = 64;

   typedef struct {
      bit [CW-1:0] count;
      bit [MW-1:0] base;
      bit [MW-1:0] multiplier;
      bit [MW-1:0] modulus;
   } series_req_type;

   typedef struct packed {
      bit [63:0] e00;
      bit [63:0] e01;
      bit [63:0] e10;
      bit [63:0] e11;
   } mat2_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [CW-1:0] req_count = '0;
   logic [MW-1:0] req_base = '0;
   logic [MW-1:0] req_multiplier = '0;
   logic [MW-1:0] req_modulus = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [MW-1:0] rsp_sum_mod;

   series_req_type req_queue[$];
   bit [MW-1:0]    pending_sums[$];
   int unsigned    error_count = 0;
   bit             req_taken = 1'b0;
   bit             rsp_taken = 1'b0;
   bit             req_quiet = 1'b0;
   bit             rsp_quiet = 1'b0;
   bit             rsp_armed = 1'b0;
   int unsigned    req_gap = 0;
   int unsigned    rsp_wait = 0;

   modular_geometric_series_sum_unit #(
      .MOD_WIDTH   (MW),
      .COUNT_WIDTH (CW)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_count      (req_count),
      .req_base       (req_base),
      .req_multiplier (req_multiplier),
      .req_modulus    (req_modulus),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sum_mod    (rsp_sum_mod)
   );

   function automatic bit [63:0] add_mod(input bit [63:0] x, input bit [63:0] y,
                                         input bit [63:0] m);
      bit [63:0] s;
      s = x + y;
      if (s >= m) s = s - m;
      return s;
   endfunction

   function automatic bit [63:0] mul_mod(input bit [63:0] x, input bit [63:0] y,
                                         input bit [63:0] m);
      bit [63:0] acc;
      acc = '0;
      while (y != 0) begin
         if (y[0]) acc = add_mod(acc, x, m);
         x = x << 1;
         if (x >= m) x = x - m;
         y = y >> 1;
      end
      return acc;
   endfunction

   function automatic mat2_type mat_product(input mat2_type p, input mat2_type q,
                                            input bit [63:0] m);
      mat2_type r;
      r.e00 = add_mod(mul_mod(p.e00, q.e00, m), mul_mod(p.e01, q.e10, m), m);
      r.e01 = add_mod(mul_mod(p.e00, q.e01, m), mul_mod(p.e01, q.e11, m), m);
      r.e10 = add_mod(mul_mod(p.e10, q.e00, m), mul_mod(p.e11, q.e10, m), m);
      r.e11 = add_mod(mul_mod(p.e10, q.e01, m), mul_mod(p.e11, q.e11, m), m);
      return r;
   endfunction

   // d * (1 + b + ... + b^(n-1)) mod m via [[b,1],[0,1]]^n
   function automatic bit [MW-1:0] geo_sum_mod(input series_req_type t);
      bit [63:0] m;
      bit [63:0] n;
      bit [63:0] s;
      mat2_type  acc;
      mat2_type  pw;
      m = 64'(t.modulus);
      if (m == 0) return '0;
      n = 64'(t.count);
      acc.e00 = 1 % m;
      acc.e01 = '0;
      acc.e10 = '0;
      acc.e11 = 1 % m;
      pw.e00 = 64'(t.base) % m;
      pw.e01 = 1 % m;
      pw.e10 = '0;
      pw.e11 = 1 % m;
      while (n != 0) begin
         if (n[0]) acc = mat_product(acc, pw, m);
         pw = mat_product(pw, pw, m);
         n = n >> 1;
      end
      s = mul_mod(64'(t.multiplier) % m, acc.e01, m);
      return s[MW-1:0];
   endfunction

   function automatic int unsigned draw_wait(inout bit quiet);
      if ($urandom_range(0, 5) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   task automatic queue_item(input bit [CW-1:0] n, input bit [MW-1:0] b,
                             input bit [MW-1:0] d, input bit [MW-1:0] m);
      series_req_type t;
      t.count = n;
      t.base = b;
      t.multiplier = d;
      t.modulus = m;
      req_queue.insert(req_queue.size(), t);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      series_req_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_valid) req_gap = draw_wait(req_quiet);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_queue.size() != 0) begin
            t = req_queue.pop_front();
            req_count <= t.count;
            req_base <= t.base;
            req_multiplier <= t.multiplier;
            req_modulus <= t.modulus;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall generator
   always @(negedge clock) begin
      if (rsp_taken) rsp_armed = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_valid !== 1'b1) begin
         rsp_stall <= !rsp_quiet && ($urandom_range(0, 1) == 1);
      end else begin
         if (!rsp_armed) begin
            rsp_armed = 1'b1;
            rsp_wait = draw_wait(rsp_quiet);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      series_req_type t;
      bit [MW-1:0]    want;
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            t.count = req_count;
            t.base = req_base;
            t.multiplier = req_multiplier;
            t.modulus = req_modulus;
            pending_sums.insert(pending_sums.size(), geo_sum_mod(t));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_sums.size() == 0) begin
               $error("sum_mod: expected none, actual %0d", rsp_sum_mod);
               error_count++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp_sum_mod !== want) begin
                  $error("sum_mod: expected %0d, actual %0d", want, rsp_sum_mod);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      bit [CW-1:0] n;
      bit [MW-1:0] b;
      bit [MW-1:0] d;
      bit [MW-1:0] m;

      // directed cases
      queue_item(64'd0, 32'd7, 32'd5, 32'd1000);
      queue_item(64'd0, '1, '1, '1);
      queue_item(64'd12345, 32'd9, 32'd8, 32'd1);
      queue_item('1, '1, '1, 32'd1);
      queue_item(64'd1, 32'd10, 32'd1234, 32'd1000);
      queue_item(64'd2, 32'd10, 32'd7, 32'd1_000_007);
      queue_item(64'd5, 32'd10, 32'd3, 32'd1_000_000_007);
      queue_item('1, '1, '1, '1);
      queue_item('1, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
      queue_item(64'h8000_0000_0000_0000, 32'd3, 32'd1, 32'hFFFF_FFFB);
      queue_item(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
      queue_item(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
      queue_item(64'd1000, 32'd0, 32'd9, 32'd97);
      queue_item(64'd1000, 32'd1, 32'd9, 32'd97);
      queue_item(64'd77, 32'd97, 32'd5, 32'd97);
      queue_item(64'd77, 32'd1000, 32'd500, 32'd97);
      queue_item(64'd77, 32'd96, 32'd0, 32'd97);
      queue_item(64'd77, 32'd96, 32'd97, 32'd97);
      queue_item(64'd31, 32'd3, 32'd1, 32'd2);
      queue_item(64'd64, 32'd2, 32'd1, 32'h8000_0000);
      queue_item(64'hFFFF_FFFF, 32'd10, 32'd9, 32'd1_000_000_007);

      // random transactions, mostly short counts
      for (int i = 0; i < 80; i++) begin
         case ($urandom_range(0, 3))
            0: m = $urandom_range(1, 16);
            1: m = $urandom;
            2: m = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: m = $urandom | 32'h8000_0000;
         endcase
         if (m == 0) m = 1;
         case ($urandom_range(0, 3))
            0: b = $urandom_range(0, 3);
            1: b = m - 32'($urandom_range(0, 2));
            default: b = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: d = $urandom_range(0, 9);
            1: d = m - 32'($urandom_range(0, 1));
            default: d = $urandom;
         endcase
         case ($urandom_range(0, 15))
            0: n = '0;
            1, 2: n = {$urandom, $urandom};
            3: n = 64'($urandom);
            default: n = 64'($urandom_range(1, 4095));
         endcase
         queue_item(n, b, d, m);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_queue.size() != 0 || req_valid || pending_sums.size() != 0)
         @(posedge clock);
      repeat (9000) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
